>>> design/isq_pkg.sv
// ---------------------------------------------------------------------------
// isq_pkg: shared types and constants for the integer square root
// widths of the operand, root, partial remainder and the item carried by
// each cell of the chain
// ---------------------------------------------------------------------------
package isq_pkg;

  localparam int INPUT_BITS  = 31;
  localparam int ROOT_BITS   = (INPUT_BITS + 1) / 2;
  localparam int RAD_W       = 2 * ROOT_BITS;
  localparam int REM_W       = ROOT_BITS + 1;
  localparam int IN_TDATA_W  = ((INPUT_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((ROOT_BITS + 7) / 8) * 8;

  // work carried from one cell to the next
  typedef struct packed {
    logic [RAD_W-1:0]     rad;   // radicand bits not yet consumed, top aligned
    logic [REM_W-1:0]     rem;   // partial remainder
    logic [ROOT_BITS-1:0] root;  // root bits settled so far
  } isq_data_t;

endpackage

>>> design/isq_cell.sv
// ---------------------------------------------------------------------------
// isq_cell: one digit step of the square root
// takes two radicand bits, settles one root bit, registers the result
// ---------------------------------------------------------------------------
module isq_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              vld_i,
  input  isq_pkg::isq_data_t dat_i,
  output logic              vld_o,
  output isq_pkg::isq_data_t dat_o
);
  import isq_pkg::*;

  logic                 vld_r;
  isq_data_t            dat_r;
  isq_data_t            dat_nxt;
  logic [REM_W+1:0]     rem_sh;
  logic [REM_W+1:0]     trial;
  logic [REM_W+1:0]     diff;
  logic                 ge;
  logic [ROOT_BITS:0]   root_sh;

  always_comb begin
    rem_sh  = {dat_i.rem, dat_i.rad[RAD_W-1 -: 2]};
    trial   = (REM_W+2)'({dat_i.root, 2'b01});
    diff    = rem_sh - trial;
    ge      = (rem_sh >= trial);
    root_sh = {dat_i.root, ge};
    dat_nxt.rad  = dat_i.rad << 2;
    dat_nxt.rem  = ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
    dat_nxt.root = root_sh[ROOT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dat_r <= dat_nxt;
    end
  end

  assign vld_o = vld_r;
  assign dat_o = dat_r;

  // remainder never exceeds twice the root settled so far
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> (dat_r.rem <= {dat_r.root, 1'b0}))
    else $error("isq_cell: remainder above twice the root");

endmodule

>>> design/integer_square_root.sv
// ---------------------------------------------------------------------------
// integer_square_root: floor square root of a 31-bit unsigned integer
// an accepted input passes through the ROOT_BITS digit cell registers to out_tvalid
// throughput: one item per cycle while the chain is not held, set by the chain of ROOT_BITS digit cells
// the whole chain holds while a result waits on out_tready
// reset (rst_n low, synchronous) clears the valid bit of every cell
// ---------------------------------------------------------------------------
module integer_square_root (
  input  logic                           clk,
  input  logic                           rst_n,
  // input item
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [isq_pkg::IN_TDATA_W-1:0]  in_tdata,   // [30:0] value, rest zero
  // result item
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [isq_pkg::OUT_TDATA_W-1:0] out_tdata   // [15:0] root
);
  import isq_pkg::*;

  // cell k takes chain slot k and drives slot k+1; the last slot is the
  // output register
  logic                vld [0:ROOT_BITS];
  isq_data_t           dat [0:ROOT_BITS];
  logic [ROOT_BITS:1]  vld_vec;
  logic                adv;

  // the chain moves when the output slot is empty or being taken
  assign adv       = !vld[ROOT_BITS] || out_tready;
  assign in_tready = adv;

  // first slot: radicand from the port, stray high bits dropped
  always_comb begin
    vld[0]      = in_tvalid;
    dat[0].rad  = RAD_W'(in_tdata[INPUT_BITS-1:0]);
    dat[0].rem  = '0;
    dat[0].root = '0;
  end

  // one cell per root bit, most significant first
  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_cell
    isq_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .vld_i (vld[k]),
      .dat_i (dat[k]),
      .vld_o (vld[k+1]),
      .dat_o (dat[k+1])
    );
    assign vld_vec[k+1] = vld[k+1];
  end

  assign out_tvalid = vld[ROOT_BITS];
  assign out_tdata  = OUT_TDATA_W'(dat[ROOT_BITS].root);

  // a held chain keeps every item in place
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_vec))
    else $error("integer_square_root: chain moved while held");

  // a moving chain loads the first cell from the input handshake
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> (vld_vec[1] == $past(in_tvalid)))
    else $error("integer_square_root: first cell missed an item");

  // an item in the last cell before the output moves on when the chain moves
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && vld_vec[ROOT_BITS-1 > 0 ? ROOT_BITS-1 : 1] && (ROOT_BITS > 1)) |=> out_tvalid)
    else $error("integer_square_root: item lost before output");

endmodule

>>> bench/isq_root_checker.sv
// ---------------------------------------------------------------------------
// isq_root_checker: result predictor and scoreboard for integer_square_root
// watches both stream channels, works out the floor square root of every
// accepted operand and compares each result item against the oldest root
// still waiting
// ---------------------------------------------------------------------------
module isq_root_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [isq_pkg::IN_TDATA_W-1:0]  in_tdata,    // [30:0] value, rest zero
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [isq_pkg::OUT_TDATA_W-1:0] out_tdata,   // [15:0] root
  output int                              error_count,
  output int                              roots_pending
);
  import isq_pkg::*;

  logic [ROOT_BITS-1:0] root_queue[$];

  // settle the root from the top bit down, keeping a bit while its square fits
  function automatic logic [ROOT_BITS-1:0] floor_sqrt(input logic [INPUT_BITS-1:0] v);
    logic [ROOT_BITS-1:0] r;
    logic [ROOT_BITS-1:0] t;
    logic [RAD_W-1:0]     sq;
    r = '0;
    for (int b = ROOT_BITS - 1; b >= 0; b--) begin
      t    = r;
      t[b] = 1'b1;
      sq   = t * t;
      if (sq <= RAD_W'(v)) r = t;
    end
    return r;
  endfunction

  assign roots_pending = root_queue.size();

  always @(posedge clk) begin
    logic [ROOT_BITS-1:0] want;
    if (!rst_n) begin
      error_count <= 0;
    end else begin
      // bits above the operand width are padding and play no part
      if (in_tvalid && in_tready)
        root_queue.push_back(floor_sqrt(in_tdata[INPUT_BITS-1:0]));
      if (out_tvalid && out_tready) begin
        if (root_queue.size() == 0) begin
          $error("unexpected result item: root %0d", out_tdata);
          error_count <= error_count + 1;
        end else begin
          want = root_queue.pop_front();
          if (out_tdata !== OUT_TDATA_W'(want)) begin
            $error("root mismatch: expected %0d, actual %0d", want, out_tdata);
            error_count <= error_count + 1;
          end
        end
      end
    end
  end

endmodule

>>> bench/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: testbench for integer_square_root
// feeds directed operands (extremes, zero and one, perfect squares and their
// neighbors, padding bits set) and then random operands shaped around square
// boundaries, with random idling on both channels; a separate checker
// predicts and scores every result item
// ---------------------------------------------------------------------------
module tb_top;
  import isq_pkg::*;

  localparam int RANDOM_ITEMS = 1550;
  localparam int QUIET_FIRST  = 600;   // items in this range run with no idling
  localparam int QUIET_LAST   = 899;
  localparam int MAX_ROOT     = 46340;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   quiet = 1'b0;  // disables idling on both sides
  int                     error_count;
  int                     roots_pending;

  // 10 unit clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  integer_square_root DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  isq_root_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .error_count   (error_count),
    .roots_pending (roots_pending)
  );

  // receiver stalls with a chance of about 12 in a hundred outside the quiet stretch
  always @(posedge clk)
    out_tready <= quiet || ($urandom_range(0, 99) >= 12);

  // one item per call; optional idle cycles first, then hold until accepted
  task automatic send_operand(input logic [IN_TDATA_W-1:0] word);
    if (!quiet) begin
      while ($urandom_range(0, 99) < 12) begin
        in_tvalid <= 1'b0;
        in_tdata  <= IN_TDATA_W'($urandom);
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // operand drawn around the places where the root steps
  function automatic logic [IN_TDATA_W-1:0] random_operand();
    int unsigned r;
    int unsigned v;
    r = $urandom_range(1, MAX_ROOT - 1);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;                          // full range
      4, 5:       v = r * r;                             // perfect square
      6:          v = r * r - 1;                         // just below a square
      7:          v = r * r + 2 * r;                     // last value of root r
      8:          v = $urandom_range(0, 1023);           // small operands
      default:    v = $urandom >> $urandom_range(0, 31); // random magnitude
    endcase
    // padding stays zero for random items
    return {1'b0, v[INPUT_BITS-1:0]};
  endfunction

  initial begin
    logic [IN_TDATA_W-1:0] directed[$];
    directed = '{
      32'd0, 32'd1, 32'd2, 32'd3, 32'd4,              // zero, one and first step
      32'd8, 32'd9, 32'd15, 32'd16,                    // squares and neighbors
      32'd65535, 32'd65536, 32'd65537,
      32'h4000_0000,                                   // top bit alone, exact square
      32'h3FFF_FFFF,
      32'd2147395599, 32'd2147395600,                  // around the largest square
      32'h7FFF_FFFE, 32'h7FFF_FFFF,                    // largest operands
      32'h5555_5555, 32'h2AAA_AAAA,                    // alternating bits
      32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0010      // padding bit set, ignored
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_operand(directed[i]);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet <= (n >= QUIET_FIRST) && (n <= QUIET_LAST);
      send_operand(random_operand());
    end
    in_tvalid <= 1'b0;
    quiet     <= 1'b0;

    // drain, then let the chain settle in case anything stray comes out
    while (roots_pending != 0) @(posedge clk);
    repeat (4 * ROOT_BITS) @(posedge clk);

    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> integer_square_root.f
design/isq_pkg.sv
design/isq_cell.sv
design/integer_square_root.sv
bench/isq_root_checker.sv
bench/tb_top.sv
